FILE: rtl/gcce_pkg.sv
`default_nettype none

package gcce_pkg;

    localparam int UNITS_PER_TILE = 128;
    localparam int TILES_PER_CELL = 8;
    localparam int CELL_UNITS     = UNITS_PER_TILE * TILES_PER_CELL;
    localparam int CELL_SHIFT     = $clog2(CELL_UNITS);
    localparam int GRID_LIMIT     = 32;
    localparam int MAX_RESULTS    = 64;

    localparam int COORD_W  = 15;
    localparam int CELL_W   = 5;
    localparam int DIM_W    = 6;
    localparam int RADIUS_W = 12;
    localparam int SPAN_W   = COORD_W + 2;
    localparam int DIST_W   = SPAN_W - 1;
    localparam int R2_W     = 2 * RADIUS_W;
    localparam int SQ_W     = 2 * DIST_W;
    localparam int CNT_W    = $clog2(MAX_RESULTS + 1);

    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;
    localparam int REG_IDX_W = APB_AW - 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GRID_COLS = 2'd0,
        REG_GRID_ROWS = 2'd1,
        REG_RADIUS    = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [DIM_W-1:0]    grid_cols;
        logic [DIM_W-1:0]    grid_rows;
        logic [RADIUS_W-1:0] radius;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [CELL_W-1:0]  col_first;
        logic [CELL_W-1:0]  col_last;
        logic [CELL_W-1:0]  row_first;
        logic [CELL_W-1:0]  row_last;
        logic [R2_W-1:0]    r2;
        logic               skip;
    } t_job;

endpackage

`default_nettype wire

FILE: rtl/gcce_in_if.sv
`default_nettype none

interface gcce_in_if;
    import gcce_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

`default_nettype wire

FILE: rtl/gcce_out_if.sv
`default_nettype none

interface gcce_out_if;
    import gcce_pkg::*;

    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic              cell_valid;
    logic              last;

    modport source (output valid, output cell_x, output cell_y, output cell_valid,
                    output last, input ready);
    modport sink   (input valid, input cell_x, input cell_y, input cell_valid,
                    input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/grid_cell_coverage_enumerator.sv
// Grid cell coverage enumerator. Each input transaction carries a world position; the block
// snaps it to its tile centre, clamps the square box of the configured radius to the grid, and
// emits every cell of that box whose rectangle the circle strictly intersects, column outer and
// row inner, with last on the final result (at most 64 results; an item covering nothing gives
// one result with cell_valid low). The scanner tests one candidate cell per cycle while the
// output register can take a result and no held final hit is being flushed; the default
// radius gives at most 6 x 6 cells. A position passes through the queue, the scanner
// registers, the test stages s1 and s2, the collector and the output register; each hit is
// held until the next hit or the end of the scan. A queue of QUEUE_DEPTH entries sits
// between input classification and the scanner, so new positions are taken while a scan
// runs, until the queue is full. Registers: grid_cols at 0x0, grid_rows at 0x4,
// influence_radius at 0x8; write them only while the block is idle.
`default_nettype none

module grid_cell_coverage_enumerator #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    gcce_in_if.sink                       i_in,
    gcce_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gcce_pkg::APB_AW-1:0]   paddr,
    input  logic [gcce_pkg::APB_DW-1:0]   pwdata,
    output logic [gcce_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import gcce_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;
    logic     push;
    logic     full;
    logic     pop;
    logic     job_valid;
    t_job     push_job;
    t_job     head_job;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_cols <= DIM_W'(GRID_LIMIT);
            r_cfg.grid_rows <= DIM_W'(GRID_LIMIT);
            r_cfg.radius    <= RADIUS_W'(2560);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_GRID_COLS: r_cfg.grid_cols <= pwdata[DIM_W-1:0];
                REG_GRID_ROWS: r_cfg.grid_rows <= pwdata[DIM_W-1:0];
                REG_RADIUS:    r_cfg.radius    <= pwdata[RADIUS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_GRID_COLS: prdata = APB_DW'(r_cfg.grid_cols);
            REG_GRID_ROWS: prdata = APB_DW'(r_cfg.grid_rows);
            REG_RADIUS:    prdata = APB_DW'(r_cfg.radius);
            default:       prdata = '0;
        endcase
    end

    gcce_front u_front (
        .i_in   (i_in),
        .i_cfg  (r_cfg),
        .i_full (full),
        .o_push (push),
        .o_job  (push_job)
    );

    gcce_queue #(
        .WIDTH ($bits(t_job)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (job_valid),
        .o_data  (head_job)
    );

    gcce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (head_job),
        .o_job_pop   (pop),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

FILE: rtl/gcce_queue.sv
`default_nettype none

module gcce_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QCNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/gcce_front.sv
`default_nettype none

module gcce_front (
    gcce_in_if.sink          i_in,
    input  gcce_pkg::t_cfg   i_cfg,
    input  logic             i_full,
    output logic             o_push,
    output gcce_pkg::t_job   o_job
);
    import gcce_pkg::*;

    localparam int IDX_W = SPAN_W - CELL_SHIFT;

    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [SPAN_W-1:0]  x_lo;
    logic [SPAN_W-1:0]  x_hi;
    logic [SPAN_W-1:0]  y_lo;
    logic [SPAN_W-1:0]  y_hi;
    logic [DIM_W-1:0]   cols;
    logic [DIM_W-1:0]   rows;

    function automatic logic [CELL_W-1:0] to_cell(input logic [SPAN_W-1:0] w,
                                                  input logic [DIM_W-1:0]  lim);
        logic [IDX_W-1:0] c;
        logic [IDX_W-1:0] top;
        c   = w[SPAN_W-1] ? '0 : IDX_W'(w >> CELL_SHIFT);
        top = IDX_W'(lim) - IDX_W'(1);
        if (c > top) begin
            c = top;
        end
        return CELL_W'(c);
    endfunction

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        cx   = COORD_W'((i_in.pos_x / UNITS_PER_TILE) * UNITS_PER_TILE + UNITS_PER_TILE / 2);
        cy   = COORD_W'((i_in.pos_y / UNITS_PER_TILE) * UNITS_PER_TILE + UNITS_PER_TILE / 2);
        x_lo = SPAN_W'(cx) - SPAN_W'(i_cfg.radius);
        x_hi = SPAN_W'(cx) + SPAN_W'(i_cfg.radius);
        y_lo = SPAN_W'(cy) - SPAN_W'(i_cfg.radius);
        y_hi = SPAN_W'(cy) + SPAN_W'(i_cfg.radius);
        cols = (i_cfg.grid_cols > DIM_W'(GRID_LIMIT)) ? DIM_W'(GRID_LIMIT) : i_cfg.grid_cols;
        rows = (i_cfg.grid_rows > DIM_W'(GRID_LIMIT)) ? DIM_W'(GRID_LIMIT) : i_cfg.grid_rows;

        o_job.cx        = cx;
        o_job.cy        = cy;
        o_job.col_first = to_cell(x_lo, cols);
        o_job.col_last  = to_cell(x_hi, cols);
        o_job.row_first = to_cell(y_lo, rows);
        o_job.row_last  = to_cell(y_hi, rows);
        o_job.r2        = R2_W'(i_cfg.radius) * R2_W'(i_cfg.radius);
        o_job.skip      = (cols == '0) || (rows == '0);
    end

endmodule

`default_nettype wire

FILE: rtl/gcce_back.sv
`default_nettype none

module gcce_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  gcce_pkg::t_job   i_job,
    output logic             o_job_pop,
    gcce_out_if.source       o_out
);
    import gcce_pkg::*;

    localparam int SUM_W = SQ_W + 1;

    // scanner
    logic               r_busy;
    logic [COORD_W-1:0] r_cx;
    logic [COORD_W-1:0] r_cy;
    logic [CELL_W-1:0]  r_col;
    logic [CELL_W-1:0]  r_row;
    logic [CELL_W-1:0]  r_row_first;
    logic [CELL_W-1:0]  r_col_last;
    logic [CELL_W-1:0]  r_row_last;
    logic [R2_W-1:0]    r_r2;
    logic               r_skip;
    logic               n_busy;
    logic [CELL_W-1:0]  n_col;
    logic [CELL_W-1:0]  n_row;

    // test pipeline
    logic               r_s1_v;
    logic [CELL_W-1:0]  r_s1_x;
    logic [CELL_W-1:0]  r_s1_y;
    logic [DIST_W-1:0]  r_s1_dx;
    logic [DIST_W-1:0]  r_s1_dy;
    logic               r_s1_end;
    logic               r_s1_skip;
    logic [R2_W-1:0]    r_s1_r2;
    logic               r_s2_v;
    logic [CELL_W-1:0]  r_s2_x;
    logic [CELL_W-1:0]  r_s2_y;
    logic [SQ_W-1:0]    r_s2_sqx;
    logic [SQ_W-1:0]    r_s2_sqy;
    logic               r_s2_zero;
    logic               r_s2_end;
    logic               r_s2_skip;
    logic [R2_W-1:0]    r_s2_r2;

    // collector
    logic               r_pend_v;
    logic [CELL_W-1:0]  r_pend_x;
    logic [CELL_W-1:0]  r_pend_y;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_flush;
    logic               n_pend_v;
    logic [CELL_W-1:0]  n_pend_x;
    logic [CELL_W-1:0]  n_pend_y;
    logic [CNT_W-1:0]   n_cnt;
    logic               n_flush;

    // output register
    logic               r_out_valid;
    logic [CELL_W-1:0]  r_out_x;
    logic [CELL_W-1:0]  r_out_y;
    logic               r_out_cv;
    logic               r_out_last;

    logic               slot_free;
    logic               advance;
    logic               issue;
    logic               cand_end;
    logic [SPAN_W-1:0]  x_lo;
    logic [SPAN_W-1:0]  y_lo;
    logic [SUM_W-1:0]   dist_sum;
    logic               hit;
    logic               take;
    logic               emit;
    logic [CELL_W-1:0]  emit_x;
    logic [CELL_W-1:0]  emit_y;
    logic               emit_cv;
    logic               emit_last;

    function automatic logic [DIST_W-1:0] gap(input logic [SPAN_W-1:0] lo);
        logic [SPAN_W-1:0] hi;
        logic [DIST_W-1:0] d;
        hi = lo + SPAN_W'(CELL_UNITS);
        if (hi[SPAN_W-1]) begin
            d = DIST_W'(SPAN_W'(0) - hi);
        end else if (!lo[SPAN_W-1] && (lo != '0)) begin
            d = DIST_W'(lo);
        end else begin
            d = '0;
        end
        return d;
    endfunction

    assign slot_free = !r_out_valid || o_out.ready;
    assign advance   = slot_free && !r_flush;
    assign o_job_pop = advance && !r_busy && i_job_valid;
    assign issue     = advance && r_busy;
    assign cand_end  = r_skip || ((r_col == r_col_last) && (r_row == r_row_last));

    assign x_lo = SPAN_W'(r_col) * SPAN_W'(CELL_UNITS) - SPAN_W'(r_cx);
    assign y_lo = SPAN_W'(r_row) * SPAN_W'(CELL_UNITS) - SPAN_W'(r_cy);

    always_comb begin
        n_busy = r_busy;
        n_col  = r_col;
        n_row  = r_row;
        if (o_job_pop) begin
            n_busy = 1'b1;
            n_col  = i_job.col_first;
            n_row  = i_job.row_first;
        end else if (issue) begin
            if (cand_end) begin
                n_busy = 1'b0;
            end else if (r_row == r_row_last) begin
                n_row = r_row_first;
                n_col = r_col + 1'b1;
            end else begin
                n_row = r_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (advance) begin
                r_s1_v <= issue;
                r_s2_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_col <= n_col;
        r_row <= n_row;
        if (o_job_pop) begin
            r_cx        <= i_job.cx;
            r_cy        <= i_job.cy;
            r_row_first <= i_job.row_first;
            r_col_last  <= i_job.col_last;
            r_row_last  <= i_job.row_last;
            r_r2        <= i_job.r2;
            r_skip      <= i_job.skip;
        end
        if (advance) begin
            r_s1_x    <= r_col;
            r_s1_y    <= r_row;
            r_s1_dx   <= gap(x_lo);
            r_s1_dy   <= gap(y_lo);
            r_s1_end  <= cand_end;
            r_s1_skip <= r_skip;
            r_s1_r2   <= r_r2;
            r_s2_x    <= r_s1_x;
            r_s2_y    <= r_s1_y;
            r_s2_sqx  <= SQ_W'(r_s1_dx) * SQ_W'(r_s1_dx);
            r_s2_sqy  <= SQ_W'(r_s1_dy) * SQ_W'(r_s1_dy);
            r_s2_zero <= (r_s1_dx == '0) && (r_s1_dy == '0);
            r_s2_end  <= r_s1_end;
            r_s2_skip <= r_s1_skip;
            r_s2_r2   <= r_s1_r2;
        end
    end

    assign dist_sum = SUM_W'(r_s2_sqx) + SUM_W'(r_s2_sqy);
    assign hit      = !r_s2_skip && (r_s2_zero || (dist_sum < SUM_W'(r_s2_r2)));
    assign take     = hit && (r_cnt != CNT_W'(MAX_RESULTS));

    // hold one hit back so the final one can carry last
    always_comb begin
        n_pend_v  = r_pend_v;
        n_pend_x  = r_pend_x;
        n_pend_y  = r_pend_y;
        n_cnt     = r_cnt;
        n_flush   = r_flush;
        emit      = 1'b0;
        emit_x    = '0;
        emit_y    = '0;
        emit_cv   = 1'b0;
        emit_last = 1'b0;
        if (r_flush) begin
            if (slot_free) begin
                emit      = 1'b1;
                emit_x    = r_pend_x;
                emit_y    = r_pend_y;
                emit_cv   = 1'b1;
                emit_last = 1'b1;
                n_pend_v  = 1'b0;
                n_flush   = 1'b0;
            end
        end else if (advance && r_s2_v) begin
            if (r_s2_end) begin
                n_cnt = '0;
                if (take && r_pend_v) begin
                    emit     = 1'b1;
                    emit_x   = r_pend_x;
                    emit_y   = r_pend_y;
                    emit_cv  = 1'b1;
                    n_pend_x = r_s2_x;
                    n_pend_y = r_s2_y;
                    n_flush  = 1'b1;
                end else if (take) begin
                    emit      = 1'b1;
                    emit_x    = r_s2_x;
                    emit_y    = r_s2_y;
                    emit_cv   = 1'b1;
                    emit_last = 1'b1;
                end else if (r_pend_v) begin
                    emit      = 1'b1;
                    emit_x    = r_pend_x;
                    emit_y    = r_pend_y;
                    emit_cv   = 1'b1;
                    emit_last = 1'b1;
                    n_pend_v  = 1'b0;
                end else begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                end
            end else if (take) begin
                n_cnt    = r_cnt + 1'b1;
                n_pend_v = 1'b1;
                n_pend_x = r_s2_x;
                n_pend_y = r_s2_y;
                if (r_pend_v) begin
                    emit    = 1'b1;
                    emit_x  = r_pend_x;
                    emit_y  = r_pend_y;
                    emit_cv = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v    <= 1'b0;
            r_cnt       <= '0;
            r_flush     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend_v <= n_pend_v;
            r_cnt    <= n_cnt;
            r_flush  <= n_flush;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_x <= n_pend_x;
        r_pend_y <= n_pend_y;
        if (emit) begin
            r_out_x    <= emit_x;
            r_out_y    <= emit_y;
            r_out_cv   <= emit_cv;
            r_out_last <= emit_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.cell_x     = r_out_x;
    assign o_out.cell_y     = r_out_y;
    assign o_out.cell_valid = r_out_cv;
    assign o_out.last       = r_out_last;

endmodule

`default_nettype wire

FILE: rtl/gcce_chk.sv
`default_nettype none

module gcce_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [gcce_pkg::CELL_W-1:0] i_cell_x,
    input logic [gcce_pkg::CELL_W-1:0] i_cell_y,
    input logic                        i_cell_valid,
    input logic                        i_last
);
    import gcce_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_cell_x) &&
        $stable(i_cell_y) && $stable(i_cell_valid) && $stable(i_last))
        else $error("result changed while stalled");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_cell_valid |-> i_last)
        else $error("empty result not marked last");

    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_cell_valid |-> (i_cell_x == '0) && (i_cell_y == '0))
        else $error("empty result carries cell coordinates");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind grid_cell_coverage_enumerator gcce_chk u_gcce_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_cell_x     (o_out.cell_x),
    .i_cell_y     (o_out.cell_y),
    .i_cell_valid (o_out.cell_valid),
    .i_last       (o_out.last)
);

`default_nettype wire

FILE: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gcce_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 40;
    localparam int NUM_PHASES    = 6;
    localparam int NUM_PROBES    = 20;

    typedef struct packed {
        logic [CELL_W-1:0] cell_x;
        logic [CELL_W-1:0] cell_y;
        logic              cell_valid;
        logic              last;
    } t_cell_result;

    typedef struct packed {
        logic [DIM_W-1:0]    cols;
        logic [DIM_W-1:0]    rows;
        logic [RADIUS_W-1:0] radius;
        logic [COORD_W-1:0]  px;
        logic [COORD_W-1:0]  py;
        logic                typed;
        logic [CELL_W-1:0]   ex;
        logic [CELL_W-1:0]   ey;
        logic                evalid;
    } t_probe_row;

    typedef enum int {
        FLOW_FREE,
        FLOW_COIN,
        FLOW_SPARSE
    } t_flow_mode;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    gcce_in_if  in_if ();
    gcce_out_if out_if ();

    grid_cell_coverage_enumerator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_cell_result        cells_due[$];
    logic [DIM_W-1:0]    cfg_cols;
    logic [DIM_W-1:0]    cfg_rows;
    logic [RADIUS_W-1:0] cfg_radius;
    int                  faults;
    int                  burst_left;
    bit                  hold_request;

    t_probe_row probes [NUM_PROBES] = '{
        '{32, 32, 2560,     0,     0, 0,  0,  0, 0},
        '{32, 32, 2560, 32767, 32767, 0,  0,  0, 0},
        '{32, 32, 2560, 16384, 16384, 0,  0,  0, 0},
        '{32, 32, 2560, 'h2AAA, 'h5555, 0, 0,  0, 0},
        '{32, 32, 2560, 'h5555, 'h2AAA, 0, 0,  0, 0},
        '{32, 32,    0,     0,     0, 1,  0,  0, 1},
        '{32, 32,    0, 32767, 32767, 1, 31, 31, 1},
        '{32, 32,   64,  1023,  1023, 0,  0,  0, 0},
        '{32, 32,   65,  1023,  1023, 0,  0,  0, 0},
        '{32, 32, 4095, 16384, 16384, 0,  0,  0, 0},
        '{32, 32, 4095,     0, 32767, 0,  0,  0, 0},
        '{ 0, 32, 2560,   500,   500, 1,  0,  0, 0},
        '{32,  0, 2560,   500,   500, 1,  0,  0, 0},
        '{63, 63, 2560, 32767,     0, 0,  0,  0, 0},
        '{33, 40, 4095, 32767, 32767, 0,  0,  0, 0},
        '{ 1,  1,    0, 32767, 32767, 1,  0,  0, 0},
        '{ 1,  1, 4095, 20000,   100, 0,  0,  0, 0},
        '{ 2,  2, 2560, 32767, 32767, 1,  0,  0, 0},
        '{ 5,  3, 1000,  4000,  2000, 0,  0,  0, 0},
        '{32, 32, 2560,  7000,  9000, 0,  0,  0, 0}
    };

    function automatic int cell_of(input int w, input int lim);
        int c;
        c = w >>> CELL_SHIFT;
        if (c < 0) begin
            c = 0;
        end
        if (c > lim - 1) begin
            c = lim - 1;
        end
        return c;
    endfunction

    function automatic void predict_coverage(input logic [COORD_W-1:0] px,
                                             input logic [COORD_W-1:0] py);
        int           cx, cy, rad, ncol, nrow, c_lo, c_hi, r_lo, r_hi, hits;
        longint       rx1, ry1, rx2, ry2, dx, dy;
        t_cell_result res;
        cx   = (int'(px) / UNITS_PER_TILE) * UNITS_PER_TILE + UNITS_PER_TILE / 2;
        cy   = (int'(py) / UNITS_PER_TILE) * UNITS_PER_TILE + UNITS_PER_TILE / 2;
        rad  = int'(cfg_radius);
        ncol = (cfg_cols > GRID_LIMIT) ? GRID_LIMIT : int'(cfg_cols);
        nrow = (cfg_rows > GRID_LIMIT) ? GRID_LIMIT : int'(cfg_rows);
        hits = 0;
        if (ncol > 0 && nrow > 0) begin
            c_lo = cell_of(cx - rad, ncol);
            c_hi = cell_of(cx + rad, ncol);
            r_lo = cell_of(cy - rad, nrow);
            r_hi = cell_of(cy + rad, nrow);
            for (int c = c_lo; c <= c_hi && hits < MAX_RESULTS; c++) begin
                for (int r = r_lo; r <= r_hi && hits < MAX_RESULTS; r++) begin
                    rx1 = longint'(c) * CELL_UNITS - cx;
                    rx2 = longint'(c + 1) * CELL_UNITS - cx;
                    ry1 = longint'(r) * CELL_UNITS - cy;
                    ry2 = longint'(r + 1) * CELL_UNITS - cy;
                    // nearest point of the cell to the centre, relative to the centre
                    dx = (rx1 > 0) ? rx1 : ((rx2 < 0) ? rx2 : 0);
                    dy = (ry1 > 0) ? ry1 : ((ry2 < 0) ? ry2 : 0);
                    if ((dx == 0 && dy == 0) ||
                        (dx * dx + dy * dy < longint'(rad) * rad)) begin
                        res.cell_x     = CELL_W'(c);
                        res.cell_y     = CELL_W'(r);
                        res.cell_valid = 1'b1;
                        res.last       = 1'b0;
                        cells_due.push_back(res);
                        hits++;
                    end
                end
            end
        end
        if (hits == 0) begin
            res = '{cell_x: '0, cell_y: '0, cell_valid: 1'b0, last: 1'b1};
            cells_due.push_back(res);
        end else begin
            cells_due[cells_due.size() - 1].last = 1'b1;
        end
    endfunction

    task automatic apb_cycle(input t_reg_idx idx, input logic wr,
                             input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_reg(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] rd;
        apb_cycle(idx, 1'b1, value, rd);
        apb_cycle(idx, 1'b0, '0, rd);
        if (rd !== value) begin
            $display("%0t: register %s readback expected %0d, got %0d",
                     $time, idx.name(), value, rd);
            faults++;
        end
    endtask

    task automatic wait_all_cells();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (cells_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic apply_setting(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows,
                                 input logic [RADIUS_W-1:0] radius);
        wait_all_cells();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        program_reg(REG_GRID_COLS, APB_DW'(cols));
        program_reg(REG_GRID_ROWS, APB_DW'(rows));
        program_reg(REG_RADIUS, APB_DW'(radius));
        cfg_cols   = cols;
        cfg_rows   = rows;
        cfg_radius = radius;
    endtask

    task automatic send_position(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                                 input logic typed, input t_cell_result typed_res);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_if.valid <= 1'b1;
        in_if.pos_x <= px;
        in_if.pos_y <= py;
        do @(posedge i_clk); while (!in_if.ready);
        if (typed) begin
            cells_due.push_back(typed_res);
        end else begin
            predict_coverage(px, py);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver
    initial begin
        t_flow_mode mode;
        int         seg_left;
        int         hold_left;
        mode      = FLOW_FREE;
        seg_left  = 0;
        hold_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                out_if.ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = t_flow_mode'($urandom_range(0, 2));
                    seg_left = $urandom_range(8, 64);
                end
                seg_left--;
                case (mode)
                    FLOW_FREE: begin
                        out_if.ready <= 1'b1;
                    end
                    FLOW_COIN: begin
                        out_if.ready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        out_if.ready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_cell_result got;
        t_cell_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = '{out_if.cell_x, out_if.cell_y, out_if.cell_valid, out_if.last};
            if (cells_due.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d valid=%0b last=%0b",
                         $time, got.cell_x, got.cell_y, got.cell_valid, got.last);
                faults++;
            end else begin
                want = cells_due.pop_front();
                if (got.cell_x !== want.cell_x || got.cell_y !== want.cell_y ||
                    got.cell_valid !== want.cell_valid || got.last !== want.last) begin
                    $display("%0t: expected x=%0d y=%0d v=%0b l=%0b, got x=%0d y=%0d v=%0b l=%0b",
                             $time, want.cell_x, want.cell_y, want.cell_valid, want.last,
                             got.cell_x, got.cell_y, got.cell_valid, got.last);
                    faults++;
                end
            end
        end
    end

    // watchdog
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (psel && penable && pready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_cell_result        typed_res;
        logic [DIM_W-1:0]    cols;
        logic [DIM_W-1:0]    rows;
        logic [RADIUS_W-1:0] radius;
        logic [COORD_W-1:0]  px;
        logic [COORD_W-1:0]  py;
        faults       = 0;
        burst_left   = 0;
        hold_request = 1'b0;
        cfg_cols     = 6'd32;
        cfg_rows     = 6'd32;
        cfg_radius   = 12'd2560;
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.pos_x  <= '0;
        in_if.pos_y  <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probes[i]) begin
            if (probes[i].cols != cfg_cols || probes[i].rows != cfg_rows ||
                probes[i].radius != cfg_radius) begin
                apply_setting(probes[i].cols, probes[i].rows, probes[i].radius);
            end
            typed_res = '{probes[i].ex, probes[i].ey, probes[i].evalid, 1'b1};
            send_position(probes[i].px, probes[i].py, probes[i].typed, typed_res);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    cols = 6'd32; rows = 6'd32; radius = 12'd2560;
                end
                2: begin
                    cols = 6'd32; rows = 6'd32; radius = 12'd4095;
                end
                3: begin
                    cols = 6'd1; rows = 6'd1; radius = 12'd0;
                end
                default: begin
                    cols   = ($urandom_range(0, 5) == 0) ? DIM_W'($urandom_range(0, 63))
                                                         : DIM_W'($urandom_range(1, 32));
                    rows   = ($urandom_range(0, 5) == 0) ? DIM_W'($urandom_range(0, 63))
                                                         : DIM_W'($urandom_range(1, 32));
                    radius = ($urandom_range(0, 2) == 0) ? RADIUS_W'($urandom_range(0, 300))
                                                         : RADIUS_W'($urandom_range(0, 4095));
                end
            endcase
            apply_setting(cols, rows, radius);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (phase == 1 && k == 5) begin
                    hold_request = 1'b1;
                end
                if (phase == 4 && k == 15) begin
                    wait_all_cells();
                end
                if ($urandom_range(0, 3) == 0) begin
                    px = COORD_W'($urandom_range(1, 31) * CELL_UNITS - 64 + $urandom_range(0, 127));
                    py = COORD_W'($urandom_range(1, 31) * CELL_UNITS - 64 + $urandom_range(0, 127));
                end else begin
                    px = COORD_W'($urandom_range(0, 32767));
                    py = COORD_W'($urandom_range(0, 32767));
                end
                send_position(px, py, 1'b0, '0);
            end
        end

        wait_all_cells();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (faults == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
